>>> hw/rtl/mvmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mvmf_pkg;

	// Default sizing of the vector store and of the element word
	localparam int MAX_COLS_DEF    = 256;
	localparam int VALUE_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int CMD_W     = 1;
	localparam int IDX_W     = 8;
	localparam int VAL_W     = 32;
	localparam int ROW_W     = 16;
	localparam int COLS_W    = 9;
	localparam int ACC_W     = 64;
	localparam int FRAC_BITS = 16;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Item commands
	localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
	localparam logic [CMD_W-1:0] CMD_MATRIX = 1'b1;

	// Register select, taken from the word address bit of paddr
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/mvmf_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface mvmf_item_if
	import mvmf_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic [IDX_W-1:0]        element_index;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, command, element_index, value, input ready);
	modport sink   (input valid, command, element_index, value, output ready);
endinterface

// Result channel
interface mvmf_result_if
	import mvmf_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [ROW_W-1:0]        row_index;
	logic signed [VAL_W-1:0] y_value;
	logic                    saturated;
	logic                    last_row;

	modport source (output valid, row_index, y_value, saturated, last_row, input ready);
	modport sink   (input valid, row_index, y_value, saturated, last_row, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/matrix_vector_multiply_fixed_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat carries                                  Handshake
// item      in   command, element_index, value                 valid/ready
// result    out  row_index, y_value, saturated, last_row       valid/ready
// APB       in   cols_in_use (0x0), rows_in_use (0x4)          psel/penable, pready=1
//
// One item is taken per cycle unless a stalled result holds item.ready low. A
// vector load writes the store at its accept edge. A matrix element goes through
// store read, multiply, accumulate and round/saturate stages to the output register.
// Reset clears counters, accumulator, stage valids and sets both registers to 1;
// the vector store is not cleared. A stalled result holds only the stages behind it
// that are full; elements that end no row drain into the accumulator freely.

module matrix_vector_multiply_fixed_unit
	import mvmf_pkg::*;
#(
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mvmf_item_if.sink              item,
	mvmf_result_if.source          result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int AW    = $clog2(MAX_COLS);
	localparam int CW    = (AW + 1 > COLS_W) ? AW + 1 : COLS_W;
	localparam int IXW   = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
	localparam int PW    = 2 * VALUE_WIDTH;
	localparam int RW    = ACC_W - FRAC_BITS + 1;
	localparam logic signed [RW-1:0] Y_HI = RW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] Y_LO = -Y_HI - RW'(1);
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

	// Configuration registers
	logic [COLS_W-1:0] cols_q;
	logic [ROW_W-1:0]  rows_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_W'(1);
			rows_q <= ROW_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_COLS: cols_q <= pwdata[COLS_W-1:0];
				REG_ROWS: rows_q <= pwdata[ROW_W-1:0];
			endcase
		end
	end

	// Read back a register
	always_comb begin
		unique case (paddr[2])
			REG_COLS: prdata = APB_DW'(cols_q);
			REG_ROWS: prdata = APB_DW'(rows_q);
		endcase
	end

	// Stage handshakes
	logic v1_s1, v2_s2, v3_s3, out_vld_q;
	logic end1_s1, end2_s2;
	logic rdy_out, en3, en2, en1;
	logic item_acc, mat_acc, load_acc;

	assign rdy_out = !out_vld_q || result.ready;
	assign en3     = !v3_s3 || rdy_out;
	assign en2     = !v2_s2 || !end2_s2 || en3;
	assign en1     = !v1_s1 || en2;

	assign item.ready = en1;
	assign item_acc   = item.valid && en1;
	assign mat_acc    = item_acc && (item.command == CMD_MATRIX);
	assign load_acc   = item_acc && (item.command == CMD_LOAD);

	// Effective dimensions and row bookkeeping
	logic [CW-1:0]    cols_ext, cols_eff;
	logic [ROW_W:0]   rows_eff;
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             row_end, row_last;

	always_comb begin
		cols_ext = CW'(cols_q);
		if (cols_ext == '0) begin
			cols_eff = CW'(1);
		end else if (cols_ext > CW'(MAX_COLS)) begin
			cols_eff = CW'(MAX_COLS);
		end else begin
			cols_eff = cols_ext;
		end
		rows_eff = (rows_q == '0) ? (ROW_W + 1)'(1) : (ROW_W + 1)'(rows_q);
		row_end  = (CW'(col_q) + CW'(1)) >= cols_eff;
		row_last = ((ROW_W + 1)'(row_q) + (ROW_W + 1)'(1)) >= rows_eff;
	end

	// Advance the column and row counters on each matrix beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (mat_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// Vector store: write loads, read the current column on matrix beats
	logic [IXW-1:0]         idx_ext;
	logic                   store_we;
	logic [VALUE_WIDTH-1:0] store_rd;

	assign idx_ext  = IXW'(item.element_index);
	assign store_we = load_acc && (idx_ext < IXW'(MAX_COLS));

	mvmf_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (MAX_COLS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (idx_ext[AW-1:0]),
		.wdata (item.value[VALUE_WIDTH-1:0]),
		.re    (mat_acc),
		.raddr (col_q),
		.rdata (store_rd)
	);

	// Stage 1: element and row tags, store data arrives alongside
	logic signed [VALUE_WIDTH-1:0] val_s1;
	logic [ROW_W-1:0]              row1_s1;
	logic                          last1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= mat_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (mat_acc) begin
			val_s1   <= item.value[VALUE_WIDTH-1:0];
			end1_s1  <= row_end;
			row1_s1  <= row_q;
			last1_s1 <= row_last;
		end
	end

	// Stage 2: product
	logic signed [PW-1:0] prod_s2;
	logic [ROW_W-1:0]     row2_s2;
	logic                 last2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_s1) begin
			prod_s2  <= val_s1 * $signed(store_rd);
			end2_s2  <= end1_s1;
			row2_s2  <= row1_s1;
			last2_s2 <= last1_s1;
		end
	end

	// Accumulate with saturation at the 64-bit range
	logic signed [ACC_W-1:0] acc_q, acc_sum;
	logic signed [ACC_W:0]   sum_wide;

	always_comb begin
		sum_wide = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(prod_s2);
		if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
			acc_sum = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sum = sum_wide[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (en2 && v2_s2) begin
			acc_q <= end2_s2 ? '0 : acc_sum;
		end
	end

	// Stage 3: finished row sum
	logic signed [ACC_W-1:0] sum_s3;
	logic [ROW_W-1:0]        row3_s3;
	logic                    last3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2 && end2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v2_s2 && end2_s2) begin
			sum_s3   <= acc_sum;
			row3_s3  <= row2_s2;
			last3_s3 <= last2_s2;
		end
	end

	// Round half up to Q16.16 and clip to the element range
	logic signed [RW-1:0] rnd;
	logic signed [RW-1:0] clip;
	logic                 clip_sat;

	always_comb begin
		rnd = $signed({sum_s3[ACC_W-1], sum_s3[ACC_W-1:FRAC_BITS]})
			+ $signed({{(RW - 1){1'b0}}, sum_s3[FRAC_BITS-1]});
		if (rnd > Y_HI) begin
			clip     = Y_HI;
			clip_sat = 1'b1;
		end else if (rnd < Y_LO) begin
			clip     = Y_LO;
			clip_sat = 1'b1;
		end else begin
			clip     = rnd;
			clip_sat = 1'b0;
		end
	end

	// Output register
	logic [ROW_W-1:0]        out_row_q;
	logic signed [VAL_W-1:0] out_y_q;
	logic                    out_sat_q;
	logic                    out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rdy_out) begin
			out_vld_q <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v3_s3) begin
			out_row_q  <= row3_s3;
			out_y_q    <= clip[VAL_W-1:0];
			out_sat_q  <= clip_sat;
			out_last_q <= last3_s3;
		end
	end

	assign result.valid     = out_vld_q;
	assign result.row_index = out_row_q;
	assign result.y_value   = out_y_q;
	assign result.saturated = out_sat_q;
	assign result.last_row  = out_last_q;

	// Input stalls only behind a full, stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (result.valid && !result.ready))
		else $error("item stalled while result side can move");

	// Column counter restarts after a row-ending element
	assert property (@(posedge clk) disable iff (!arst_n)
		(mat_acc && row_end) |=> (col_q == '0))
		else $error("column counter did not restart at row end");

	// Accumulator clears once a row sum leaves stage 2
	assert property (@(posedge clk) disable iff (!arst_n)
		(en2 && v2_s2 && end2_s2) |=> (acc_q == '0))
		else $error("accumulator not cleared after row end");

	// A stalled row sum in stage 3 waits on a full output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && !en3) |-> (out_vld_q && !result.ready))
		else $error("row sum held without a stalled result");

endmodule

`default_nettype wire

>>> hw/rtl/mvmf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mvmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> bench/matrix_vector_multiply_fixed_unit_tb.sv
`timescale 1ns / 1ps

module matrix_vector_multiply_fixed_unit_tb
	import mvmf_pkg::*;
();

	localparam int     RANDOM_BEATS = 1800;
	localparam int     PIPE_SETTLE  = 8;
	localparam longint Y_MAX        = 64'sh0000_0000_7FFF_FFFF;
	localparam longint Y_MIN        = -Y_MAX - 1;
	localparam longint ACC_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint ACC_MIN      = -ACC_MAX - 1;

	typedef struct packed {
		logic [ROW_W-1:0]        row_index;
		logic signed [VAL_W-1:0] y_value;
		logic                    saturated;
		logic                    last_row;
	} row_result_t;

	typedef enum logic [1:0] {STEP_BEAT, STEP_SET_COLS, STEP_SET_ROWS} step_kind_t;

	typedef struct packed {
		step_kind_t       kind;
		logic [CMD_W-1:0] command;
		logic [IDX_W-1:0] index;
		logic [31:0]      data;
		logic             typed;
		row_result_t      want;
	} plan_step_t;

	// Directed opening: extremes, rounding ties, saturation, register corner values
	localparam plan_step_t DIRECTED_PLAN [0:24] = '{
		'{STEP_BEAT, CMD_LOAD, 8'd0, 32'h0001_0000, 1'b0, '0},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h0002_0000, 1'b1, '{16'd0, 32'sh0002_0000, 1'b0, 1'b1}},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h7FFF_FFFF, 1'b1, '{16'd0, 32'sh7FFF_FFFF, 1'b0, 1'b1}},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h8000_0000, 1'b1, '{16'd0, 32'sh8000_0000, 1'b0, 1'b1}},
		'{STEP_BEAT, CMD_LOAD, 8'd255, 32'h8000_0000, 1'b0, '0},
		'{STEP_BEAT, CMD_LOAD, 8'd0, 32'h8000_0000, 1'b0, '0},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h8000_0000, 1'b1, '{16'd0, 32'sh7FFF_FFFF, 1'b1, 1'b1}},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h7FFF_FFFF, 1'b1, '{16'd0, 32'sh8000_0000, 1'b1, 1'b1}},
		'{STEP_BEAT, CMD_LOAD, 8'd0, 32'h0000_0001, 1'b0, '0},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h0000_8000, 1'b1, '{16'd0, 32'sh0000_0001, 1'b0, 1'b1}},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'hFFFF_8000, 1'b1, '{16'd0, 32'sh0000_0000, 1'b0, 1'b1}},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h0000_7FFF, 1'b1, '{16'd0, 32'sh0000_0000, 1'b0, 1'b1}},
		'{STEP_SET_COLS, CMD_LOAD, 8'd0, 32'd0, 1'b0, '0},
		'{STEP_BEAT, CMD_MATRIX, 8'hA5, 32'hFFFF_FFFF, 1'b0, '0},
		'{STEP_SET_COLS, CMD_LOAD, 8'd0, 32'd2, 1'b0, '0},
		'{STEP_SET_ROWS, CMD_LOAD, 8'd0, 32'd0, 1'b0, '0},
		'{STEP_BEAT, CMD_LOAD, 8'd1, 32'h8000_0000, 1'b0, '0},
		'{STEP_BEAT, CMD_LOAD, 8'd0, 32'h8000_0000, 1'b0, '0},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h8000_0000, 1'b0, '0},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h8000_0000, 1'b1, '{16'd0, 32'sh7FFF_FFFF, 1'b1, 1'b1}},
		'{STEP_SET_COLS, CMD_LOAD, 8'd0, 32'd1, 1'b0, '0},
		'{STEP_SET_ROWS, CMD_LOAD, 8'd0, 32'd3, 1'b0, '0},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h0003_0000, 1'b0, '0},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'h1234_5678, 1'b0, '0},
		'{STEP_BEAT, CMD_MATRIX, 8'd0, 32'hFFFE_0000, 1'b0, '0}
	};

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	mvmf_item_if   item_ch ();
	mvmf_result_if result_ch ();

	matrix_vector_multiply_fixed_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Mirror of the block state
	logic signed [VAL_W-1:0] x_mirror [0:MAX_COLS_DEF-1];
	longint                  acc_mirror;
	int                      col_mirror;
	int                      row_mirror;
	logic [COLS_W-1:0]       cols_reg;
	logic [ROW_W-1:0]        rows_reg;

	row_result_t pending_rows [$];
	int          mismatch_count = 0;
	bit          send_calm = 1'b0;
	bit          take_calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the dot product by one beat; return 1 when a row completes
	function automatic bit advance_dot_product(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val,
			output row_result_t row);
		longint prod;
		longint sum;
		longint y;
		int     ncols;
		int     nrows;
		bit     last;
		row = '0;
		if (cmd == CMD_LOAD) begin
			x_mirror[idx] = val;
			return 1'b0;
		end
		ncols = (cols_reg == '0) ? 1 : (cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_reg);
		nrows = (rows_reg == '0) ? 1 : int'(rows_reg);
		if (col_mirror >= MAX_COLS_DEF)
			col_mirror = MAX_COLS_DEF - 1;
		prod = longint'(val) * longint'(x_mirror[col_mirror]);
		sum  = acc_mirror + prod;
		// clip the accumulator when two like-signed addends wrap
		if (acc_mirror[63] == prod[63] && sum[63] != prod[63])
			sum = prod[63] ? ACC_MIN : ACC_MAX;
		acc_mirror = sum;
		col_mirror++;
		if (col_mirror < ncols)
			return 1'b0;
		// round half up to Q16.16, then clip to the word
		y = (acc_mirror >>> FRAC_BITS) + longint'(acc_mirror[FRAC_BITS-1]);
		if (y > Y_MAX) begin
			y = Y_MAX;
			row.saturated = 1'b1;
		end
		if (y < Y_MIN) begin
			y = Y_MIN;
			row.saturated = 1'b1;
		end
		last          = (row_mirror + 1 >= nrows);
		row.row_index = row_mirror[ROW_W-1:0];
		row.y_value   = y[VAL_W-1:0];
		row.last_row  = last;
		acc_mirror    = 0;
		col_mirror    = 0;
		row_mirror    = last ? 0 : row_mirror + 1;
		return 1'b1;
	endfunction

	function automatic int draw_wait(input bit calm);
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, 17);
	endfunction

	// Half small Q16.16 values so sums stay in range, the rest extremes or random words
	function automatic logic [VAL_W-1:0] draw_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom();
			default: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h0010_0000;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic drive_element_beat(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
			input logic typed, input row_result_t typed_row);
		int          gap;
		row_result_t row;
		gap = draw_wait(send_calm);
		// drop valid only for a real gap so back-to-back beats keep it high
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.command       <= cmd;
		item_ch.element_index <= idx;
		item_ch.value         <= val;
		do @(posedge clk); while (!item_ch.ready);
		if (advance_dot_product(cmd, idx, val, row))
			pending_rows.push_back(typed ? typed_row : row);
	endtask

	// Drain the pipeline, then write one register through a setup and access cycle
	task automatic program_register(input logic reg_sel, input logic [APB_DW-1:0] data);
		item_ch.valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_COLS)
			cols_reg = data[COLS_W-1:0];
		else
			rows_reg = data[ROW_W-1:0];
	endtask

	initial begin : stimulus
		int                beats_sent;
		int                ncols;
		int                nrows;
		int                nload;
		int                total;
		int                stop_at;
		int                pick;
		bit                backward;
		logic [COLS_W-1:0] cols_val;
		logic [ROW_W-1:0]  rows_val;
		plan_step_t        step;

		item_ch.valid         <= 1'b0;
		item_ch.command       <= CMD_LOAD;
		item_ch.element_index <= '0;
		item_ch.value         <= '0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		cols_reg   = 9'd1;
		rows_reg   = 16'd1;
		acc_mirror = 0;
		col_mirror = 0;
		row_mirror = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
			step = DIRECTED_PLAN[i];
			case (step.kind)
				STEP_BEAT: drive_element_beat(step.command, step.index, step.data,
						step.typed, step.want);
				STEP_SET_COLS: program_register(REG_COLS, step.data);
				default: program_register(REG_ROWS, step.data);
			endcase
		end

		// Random phases: new shape, full vector load, then rows with noise loads
		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			pick = $urandom_range(0, 23);
			if (pick == 0)
				cols_val = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511));
			else if (pick == 1)
				cols_val = 9'd0;
			else
				cols_val = 9'($urandom_range(1, (pick < 6) ? 32 : 6));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				rows_val = 16'hFFFF;
			else if (pick == 1)
				rows_val = 16'd0;
			else if (pick == 2)
				rows_val = 16'($urandom_range(7, 65534));
			else
				rows_val = 16'($urandom_range(1, 6));

			if ($urandom_range(0, 1)) begin
				program_register(REG_COLS, 32'(cols_val));
				program_register(REG_ROWS, 32'(rows_val));
			end else begin
				program_register(REG_ROWS, 32'(rows_val));
				program_register(REG_COLS, 32'(cols_val));
			end
			send_calm = ($urandom_range(0, 3) == 0);
			take_calm = ($urandom_range(0, 3) == 0);

			ncols = (cols_val == '0) ? 1 : (cols_val > MAX_COLS_DEF) ? MAX_COLS_DEF
					: int'(cols_val);
			nrows = (rows_val == '0) ? 1 : int'(rows_val);
			if (ncols > 32)
				nrows = 1;
			else if (nrows > 6)
				nrows = $urandom_range(1, 4);
			else
				nrows = nrows * $urandom_range(1, 2);

			// load the vector in either order so every read hits a written entry,
			// including the column where a row cut short earlier resumes
			nload    = (col_mirror + 1 > ncols) ? col_mirror + 1 : ncols;
			backward = $urandom_range(0, 1);
			for (int c = 0; c < nload; c++) begin
				drive_element_beat(CMD_LOAD, 8'(backward ? nload - 1 - c : c), draw_value(),
						1'b0, '0);
				beats_sent++;
			end

			// occasionally cut a phase short, which may leave a row unfinished
			total   = nrows * ncols;
			stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : -1;
			for (int e = 0; e < total && e != stop_at; e++) begin
				if ($urandom_range(0, 9) == 0) begin
					drive_element_beat(CMD_LOAD, 8'($urandom()), draw_value(), 1'b0, '0);
					beats_sent++;
				end
				drive_element_beat(CMD_MATRIX, 8'($urandom()), draw_value(), 1'b0, '0);
				beats_sent++;
			end
		end

		item_ch.valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Accept result beats with random stalls and compare against the oldest row
	initial begin : result_sink
		int          stall;
		row_result_t want;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(take_calm);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			if (pending_rows.size() == 0) begin
				$error("result beat for row %0d with no row pending", result_ch.row_index);
				mismatch_count++;
			end else begin
				want = pending_rows.pop_front();
				check_field("row_index", 32'(want.row_index), 32'(result_ch.row_index));
				check_field("y_value", want.y_value, result_ch.y_value);
				check_field("saturated", 32'(want.saturated), 32'(result_ch.saturated));
				check_field("last_row", 32'(want.last_row), 32'(result_ch.last_row));
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/mvmf_pkg.sv
hw/rtl/mvmf_if.sv
hw/rtl/mvmf_ram.sv
hw/rtl/matrix_vector_multiply_fixed_unit.sv
bench/matrix_vector_multiply_fixed_unit_tb.sv
